@@ hdl/hexu_pkg.sv @@
// hexu_pkg: shared types, status codes and utf-8 byte helper for the hex escape encoder
// no dependencies
package hexu_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_BADHEX   = 2'd2,
    ST_BADCOUNT = 2'd3
  } status_e;

  localparam int CP_W     = 21;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [31:0]     CP_MAX   = 32'h0010_FFFF;
  localparam logic [CP_W-1:0] TOP1     = 21'h00007F;
  localparam logic [CP_W-1:0] TOP2     = 21'h0007FF;
  localparam logic [CP_W-1:0] TOP3     = 21'h00FFFF;
  localparam logic [7:0]      CONT_TAG = 8'h80;
  localparam logic [7:0]      LEAD2    = 8'hC0;
  localparam logic [7:0]      LEAD3    = 8'hE0;
  localparam logic [7:0]      LEAD4    = 8'hF0;

  // one decoded escape: code point, byte count minus one, status
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [1:0]      nbm1;
    status_e         status;
  } job_t;

  function automatic logic [7:0] utf8_byte(input job_t job, input logic [1:0] idx);
    logic [1:0] rem;
    logic [7:0] b;
    rem = 2'(job.nbm1 - idx);
    b   = 8'h00;
    if (idx == 2'd0) begin
      unique case (job.nbm1)
        2'd0: b = {1'b0, job.cp[6:0]};
        2'd1: b = LEAD2 | {3'b000, job.cp[10:6]};
        2'd2: b = LEAD3 | {4'h0, job.cp[15:12]};
        2'd3: b = LEAD4 | {5'b00000, job.cp[20:18]};
        default: b = 8'h00;
      endcase
    end else begin
      unique case (rem)
        2'd0: b = CONT_TAG | {2'b00, job.cp[5:0]};
        2'd1: b = CONT_TAG | {2'b00, job.cp[11:6]};
        2'd2: b = CONT_TAG | {2'b00, job.cp[17:12]};
        default: b = CONT_TAG;
      endcase
    end
    return b;
  endfunction

endpackage

@@ hdl/hexu_in_if.sv @@
// hexu_in_if: input channel carrying one hex character item
// no dependencies
interface hexu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_char;
  logic       final_digit;

  modport source (output valid, output hex_char, output final_digit, input ready);
  modport sink   (input valid, input hex_char, input final_digit, output ready);
endinterface

@@ hdl/hexu_out_if.sv @@
// hexu_out_if: output channel carrying one utf-8 byte item
// no dependencies
interface hexu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_run;
  logic [1:0] status;

  modport source (output valid, output out_byte, output end_of_run, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input end_of_run, input status,
                  output ready);
endinterface

@@ hdl/hexu_front.sv @@
// hexu_front: accumulates hex digits and classifies each finished escape into a job
// depends on hexu_pkg and hexu_in_if
module hexu_front
  import hexu_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hexu_in_if.sink   in_i,
  input  logic      full_i,
  output logic      push_o,
  output job_t      job_o
);

  localparam int ACC_W = 4 * MAX_DIGITS;

  logic [ACC_W-1:0] acc_q, acc_d, acc_nxt;
  logic [3:0]       cnt_q, cnt_d, cnt_nxt;
  logic             bad_q, bad_d, bad_nxt;
  logic [3:0]       nib;
  logic             is_hex;
  logic             accept;
  logic             count_ok;
  logic [31:0]      cp32;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept && in_i.final_digit;

  always_comb begin
    nib    = 4'h0;
    is_hex = 1'b1;
    priority if (in_i.hex_char >= 8'h30 && in_i.hex_char <= 8'h39) begin
      nib = in_i.hex_char[3:0];
    end else if ((in_i.hex_char >= 8'h61 && in_i.hex_char <= 8'h66) ||
                 (in_i.hex_char >= 8'h41 && in_i.hex_char <= 8'h46)) begin
      nib = 4'(in_i.hex_char[3:0] + 4'd9);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign acc_nxt  = {acc_q[ACC_W-5:0], nib};
  assign cnt_nxt  = (cnt_q == 4'hF) ? cnt_q : 4'(cnt_q + 4'd1);
  assign bad_nxt  = bad_q || !is_hex;
  assign cp32     = 32'(acc_nxt);
  assign count_ok = (cnt_nxt == 4'd4) || ((cnt_nxt == 4'd8) && (MAX_DIGITS >= 8));

  always_comb begin
    job_o.cp     = '0;
    job_o.nbm1   = 2'd0;
    job_o.status = ST_OK;
    priority if (!count_ok) begin
      job_o.status = ST_BADCOUNT;
    end else if (bad_nxt) begin
      job_o.status = ST_BADHEX;
    end else if (cp32 > CP_MAX) begin
      job_o.status = ST_RANGE;
    end else begin
      job_o.cp = cp32[CP_W-1:0];
      priority if (job_o.cp <= TOP1) begin
        job_o.nbm1 = 2'd0;
      end else if (job_o.cp <= TOP2) begin
        job_o.nbm1 = 2'd1;
      end else if (job_o.cp <= TOP3) begin
        job_o.nbm1 = 2'd2;
      end else begin
        job_o.nbm1 = 2'd3;
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    bad_d = bad_q;
    if (accept) begin
      if (in_i.final_digit) begin
        acc_d = '0;
        cnt_d = 4'd0;
        bad_d = 1'b0;
      end else begin
        acc_d = acc_nxt;
        cnt_d = cnt_nxt;
        bad_d = bad_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= 4'd0;
      bad_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      bad_q <= bad_d;
    end
  end

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (cnt_q == 4'd0) && !bad_q && (acc_q == '0))
    else $error("front state not cleared after final character");

  a_ok_job_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && job_o.status != ST_OK) |-> (job_o.nbm1 == 2'd0) && (job_o.cp == '0))
    else $error("error job carries payload");

endmodule

@@ hdl/hexu_queue.sv @@
// hexu_queue: two-entry job queue between the classifier and the byte emitter
// depends on hexu_pkg
module hexu_queue
  import hexu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? QPTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? QPTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (!do_push && do_pop) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

@@ hdl/hexu_back.sv @@
// hexu_back: emits the bytes of each queued job through a registered output stage
// depends on hexu_pkg and hexu_out_if
module hexu_back
  import hexu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  hexu_out_if.source out_o
);

  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;
  logic [1:0] ostat_q, ostat_d;
  logic [1:0] idx_q, idx_d;
  logic       load, emit, is_last;

  assign load    = !ovalid_q || out_o.ready;
  assign emit    = load && valid_i;
  assign is_last = (idx_q == job_i.nbm1);
  assign pop_o   = emit && is_last;

  always_comb begin
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    ostat_d  = ostat_q;
    idx_d    = idx_q;
    if (load) begin
      ovalid_d = valid_i;
    end
    if (emit) begin
      obyte_d = utf8_byte(job_i, idx_q);
      olast_d = is_last;
      ostat_d = job_i.status;
      idx_d   = is_last ? 2'd0 : 2'(idx_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      idx_q    <= 2'd0;
    end else begin
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.end_of_run = olast_q;
  assign out_o.status     = ostat_q;

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> out_o.end_of_run && (out_o.out_byte == 8'h00))
    else $error("error result not a single zero item");

  a_pop_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_o.valid && out_o.end_of_run)
    else $error("job retired without final byte");

endmodule

@@ hdl/hex_escape_to_utf8_encoder_unit.sv @@
// hex_escape_to_utf8_encoder_unit: top level, hex escape text in, utf-8 bytes out
// depends on hexu_pkg, hexu_in_if, hexu_out_if, hexu_front, hexu_queue, hexu_back
//
//  port    dir  items                              payload
//  in_i    in   one ascii character of an escape   hex_char[7:0], final_digit
//  out_o   out  one utf-8 byte or one error item   out_byte[7:0], end_of_run, status[1:0]
//
// a character is taken every cycle while the two-entry job queue has room
// the final character is classified in its accept cycle; its job is written into the queue,
// its first byte then into the output register for out_o, and then one byte per cycle
// follows while out_o is ready (1 to 4 per escape); the byte emitter sets throughput
// out_o stalls hold the output register, fill the queue and then drop in_i.ready
// rst_ni clears the digit accumulator, queue pointers and output valid
module hex_escape_to_utf8_encoder_unit
  import hexu_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hexu_in_if.sink    in_i,
  hexu_out_if.source out_o
);

  logic push, full, pop, qvalid;
  job_t job_in, job_out;

  hexu_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .job_o (job_in)
  );

  hexu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(qvalid),
    .job_o  (job_out)
  );

  hexu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(qvalid),
    .job_i  (job_out),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
